@@ sv/topo_pkg.sv @@
// Shared types and constants for the topological sorter.
// Used by topo_ctrl, topo_dp and topological_sort_kahn; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package topo_pkg;

  localparam int CNT_W  = 7;
  localparam int VTX_W  = 6;
  localparam int STAT_W = 2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_SORT = 1'b1;

  localparam logic [STAT_W-1:0] ST_ORDER  = 2'd0;
  localparam logic [STAT_W-1:0] ST_CYCLE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_STORED = 2'd2;
  localparam logic [STAT_W-1:0] ST_REJECT = 2'd3;

  typedef struct packed {
    logic add_accept;
    logic sort_start;
    logic idx_clr;
    logic idx_inc;
    logic deg_zero_wr;
    logic eidx_clr;
    logic eidx_inc;
    logic deg_addr_tgt;
    logic deg_inc_wr;
    logic deg_dec_wr;
    logic scan_push;
    logic fifo_addr_idx;
    logic u_load;
    logic out_order;
    logic out_cycle;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic eidx_end;
    logic edge_live;
    logic edge_match;
    logic queue_empty;
    logic all_out;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ sv/topo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module topo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/topo_dp.sv @@
// Datapath of the topological sorter: edge table, degree and queue memories,
// counters and the output register. Depends on topo_pkg and topo_ram.
`timescale 1ns / 1ps
`default_nettype none
module topo_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [topo_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic [topo_pkg::VTX_W-1:0] src_vertex,
  input  wire logic [topo_pkg::VTX_W-1:0] dst_vertex,
  input  wire topo_pkg::cmd_t             cmd,
  output topo_pkg::stat_t                 stat,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic [topo_pkg::VTX_W-1:0]      out_vertex,
  output logic [topo_pkg::STAT_W-1:0]     out_status,
  output logic                            out_last
);
  import topo_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int EW1 = $clog2(MAX_EDGES + 1);

  logic [CNT_W-1:0] vertex_count;
  logic [CNT_W-1:0] n_eff;
  logic [EW1-1:0]   edge_total;
  logic [EW1-1:0]   eidx;
  logic [VW-1:0]    idx;
  logic [CNT_W-1:0] head;
  logic [CNT_W-1:0] tail;
  logic [VTX_W-1:0] u;

  logic [2*VTX_W-1:0] edge_rdata;
  logic [VTX_W-1:0]   e_src;
  logic [VTX_W-1:0]   e_tgt;
  logic [EW1-1:0]     deg_rdata;
  logic [EW1-1:0]     deg_wdata;
  logic [VW-1:0]      deg_raddr;
  logic [VW-1:0]      deg_waddr;
  logic               deg_we;
  logic [VTX_W-1:0]   fifo_rdata;
  logic [VTX_W-1:0]   fifo_wdata;
  logic [VW-1:0]      fifo_raddr;
  logic               fifo_we;
  logic               add_ok;
  logic               deg_zero;
  logic               deg_one;
  logic               out_free;

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (vertex_count > CNT_W'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
  end

  assign e_src    = edge_rdata[VTX_W-1:0];
  assign e_tgt    = edge_rdata[2*VTX_W-1:VTX_W];
  assign deg_zero = (deg_rdata == '0);
  assign deg_one  = (deg_rdata == EW1'(1));
  assign out_free = !out_valid || out_ready;
  assign add_ok   = (edge_total < EW1'(MAX_EDGES)) && (CNT_W'(src_vertex) < n_eff)
                    && (CNT_W'(dst_vertex) < n_eff);

  assign stat.idx_last    = (CNT_W'(idx) == n_eff - CNT_W'(1));
  assign stat.eidx_end    = (eidx == edge_total);
  assign stat.edge_live   = (CNT_W'(e_src) < n_eff) && (CNT_W'(e_tgt) < n_eff);
  assign stat.edge_match  = (e_src == u) && (CNT_W'(e_tgt) < n_eff);
  assign stat.queue_empty = (head == tail);
  assign stat.all_out     = (tail == n_eff);
  assign stat.out_free    = out_free;

  assign deg_raddr  = cmd.deg_addr_tgt ? e_tgt[VW-1:0] : idx;
  assign deg_waddr  = cmd.deg_zero_wr ? idx : e_tgt[VW-1:0];
  assign deg_we     = cmd.deg_zero_wr || cmd.deg_inc_wr || (cmd.deg_dec_wr && !deg_zero);
  assign deg_wdata  = cmd.deg_zero_wr ? '0 :
                      cmd.deg_inc_wr  ? deg_rdata + EW1'(1) : deg_rdata - EW1'(1);
  assign fifo_we    = (cmd.scan_push && deg_zero) || (cmd.deg_dec_wr && deg_one);
  assign fifo_wdata = cmd.scan_push ? VTX_W'(idx) : e_tgt;
  assign fifo_raddr = cmd.fifo_addr_idx ? idx : head[VW-1:0];

  topo_ram #(.WIDTH(2*VTX_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (cmd.add_accept && add_ok),
    .waddr (edge_total[EW-1:0]),
    .wdata ({dst_vertex, src_vertex}),
    .raddr (eidx[EW-1:0]),
    .rdata (edge_rdata)
  );

  topo_ram #(.WIDTH(EW1), .DEPTH(MAX_VERTICES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  topo_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail[VW-1:0]),
    .wdata (fifo_wdata),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(64);
      edge_total   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (cmd.add_accept && add_ok) begin
        edge_total <= edge_total + EW1'(1);
      end
      if (cmd.add_accept || cmd.out_order || cmd.out_cycle) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_start || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + VW'(1);
    end
    if (cmd.sort_start || cmd.eidx_clr || cmd.u_load) begin
      eidx <= '0;
    end else if (cmd.eidx_inc) begin
      eidx <= eidx + EW1'(1);
    end
    if (cmd.sort_start) begin
      head <= '0;
    end else if (cmd.u_load) begin
      head <= head + CNT_W'(1);
    end
    if (cmd.sort_start) begin
      tail <= '0;
    end else if (fifo_we) begin
      tail <= tail + CNT_W'(1);
    end
    if (cmd.u_load) begin
      u <= fifo_rdata;
    end
    if (cmd.add_accept) begin
      out_vertex <= '0;
      out_status <= add_ok ? ST_STORED : ST_REJECT;
      out_last   <= 1'b1;
    end else if (cmd.out_cycle) begin
      out_vertex <= '0;
      out_status <= ST_CYCLE;
      out_last   <= 1'b1;
    end else if (cmd.out_order) begin
      out_vertex <= fifo_rdata;
      out_status <= ST_ORDER;
      out_last   <= stat.idx_last;
    end
  end

endmodule
`default_nettype wire

@@ sv/topo_ctrl.sv @@
// Sequencer of the topological sorter: steps the datapath through clearing,
// degree counting, queue scan, edge walks and output. Depends on topo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module topo_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_op,
  output logic                 in_ready,
  input  wire topo_pkg::stat_t stat,
  output topo_pkg::cmd_t       cmd
);
  import topo_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLR    = 4'd1;
  localparam logic [3:0] S_E_RD   = 4'd2;
  localparam logic [3:0] S_E_WAIT = 4'd3;
  localparam logic [3:0] S_E_RMW  = 4'd4;
  localparam logic [3:0] S_S_RD   = 4'd5;
  localparam logic [3:0] S_S_CHK  = 4'd6;
  localparam logic [3:0] S_P_CHK  = 4'd7;
  localparam logic [3:0] S_P_WAIT = 4'd8;
  localparam logic [3:0] S_W_RD   = 4'd9;
  localparam logic [3:0] S_W_WAIT = 4'd10;
  localparam logic [3:0] S_W_RMW  = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;
  localparam logic [3:0] S_O_CYC  = 4'd13;
  localparam logic [3:0] S_O_RD   = 4'd14;
  localparam logic [3:0] S_O_LD   = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE) && stat.out_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && stat.out_free) begin
          if (in_op == OP_ADD) begin
            cmd.add_accept = 1'b1;
          end else begin
            cmd.sort_start = 1'b1;
            state_next     = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.deg_zero_wr = 1'b1;
        if (stat.idx_last) begin
          state_next = S_E_RD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_E_RD: begin
        if (stat.eidx_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_S_RD;
        end else begin
          state_next = S_E_WAIT;
        end
      end
      S_E_WAIT: begin
        cmd.deg_addr_tgt = 1'b1;
        if (stat.edge_live) begin
          state_next = S_E_RMW;
        end else begin
          cmd.eidx_inc = 1'b1;
          state_next   = S_E_RD;
        end
      end
      S_E_RMW: begin
        cmd.deg_inc_wr = 1'b1;
        cmd.eidx_inc   = 1'b1;
        state_next     = S_E_RD;
      end
      S_S_RD: begin
        state_next = S_S_CHK;
      end
      S_S_CHK: begin
        cmd.scan_push = 1'b1;
        if (stat.idx_last) begin
          state_next = S_P_CHK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_S_RD;
        end
      end
      S_P_CHK: begin
        state_next = stat.queue_empty ? S_FIN : S_P_WAIT;
      end
      S_P_WAIT: begin
        cmd.u_load = 1'b1;
        state_next = S_W_RD;
      end
      S_W_RD: begin
        state_next = stat.eidx_end ? S_P_CHK : S_W_WAIT;
      end
      S_W_WAIT: begin
        cmd.deg_addr_tgt = 1'b1;
        if (stat.edge_match) begin
          state_next = S_W_RMW;
        end else begin
          cmd.eidx_inc = 1'b1;
          state_next   = S_W_RD;
        end
      end
      S_W_RMW: begin
        cmd.deg_dec_wr = 1'b1;
        cmd.eidx_inc   = 1'b1;
        state_next     = S_W_RD;
      end
      S_FIN: begin
        cmd.idx_clr = 1'b1;
        state_next  = stat.all_out ? S_O_RD : S_O_CYC;
      end
      S_O_CYC: begin
        if (stat.out_free) begin
          cmd.out_cycle = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_O_RD: begin
        cmd.fifo_addr_idx = 1'b1;
        state_next        = S_O_LD;
      end
      S_O_LD: begin
        cmd.fifo_addr_idx = 1'b1;
        if (stat.out_free) begin
          cmd.out_order = 1'b1;
          if (stat.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_O_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/topological_sort_kahn.sv @@
// Top level of the topological sorter: stream ports, sequencer and datapath.
// Depends on topo_pkg, topo_ctrl, topo_dp and topo_ram.
//
// Add items are taken one per cycle while the output is free, each giving
// one result; each stores one directed edge unless the edge table is full or
// a vertex is out of range, when it is rejected. A sort item runs Kahn's
// algorithm over vertices 0 to n-1 and blocks input until its last result is
// taken. It counts degrees and seeds the queue, then each dequeued vertex
// walks the whole edge table through one RAM read port. Finally each order
// result is read from the queue and then loaded, or a lone cycle status is sent.
`timescale 1ns / 1ps
`default_nettype none
module topological_sort_kahn #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,   // vertex_count
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // src_vertex[5:0], dst_vertex[11:6]
  input  wire logic        s_axis_tuser,  // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // vertex[5:0]
  output logic [1:0]       m_axis_tuser,  // status[1:0]
  output logic             m_axis_tlast
);
  import topo_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic [VTX_W-1:0]   out_vertex;
  logic [STAT_W-1:0]  out_status;

  topo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  topo_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .src_vertex  (s_axis_tdata[5:0]),
    .dst_vertex  (s_axis_tdata[11:6]),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_vertex  (out_vertex),
    .out_status  (out_status),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_vertex};
  assign m_axis_tuser = out_status;

endmodule
`default_nettype wire
